// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   // register widths and reset values
   localparam int HalfPeriodWidth   = 16;
   localparam int AckTimeoutWidth   = 8;
   localparam int CsrDataWidth      = 16;
   localparam int CsrIndexWidth     = 1;
   localparam int ByteWidth         = 8;
   localparam int BitCountWidth     = 4;
   localparam int CmdWidth          = 3;
   localparam int DefaultQueueDepth = 2;

   localparam logic [HalfPeriodWidth-1:0] HalfPeriodReset = 16'd2;
   localparam logic [AckTimeoutWidth-1:0] AckTimeoutReset = 8'd250;
   localparam logic [BitCountWidth-1:0]   BitsPerByte     = 4'd8;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_HALF_PERIOD = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ACK_TIMEOUT = 1'd1;

   // command codes as they arrive on the request channel
   localparam logic [CmdWidth-1:0] CODE_NONE     = 3'd0;
   localparam logic [CmdWidth-1:0] CODE_START    = 3'd1;
   localparam logic [CmdWidth-1:0] CODE_STOP     = 3'd2;
   localparam logic [CmdWidth-1:0] CODE_WRITE    = 3'd3;
   localparam logic [CmdWidth-1:0] CODE_WAIT_ACK = 3'd4;
   localparam logic [CmdWidth-1:0] CODE_READ     = 3'd5;

   // decoded command kind
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_WAIT_ACK,
      CMD_READ
   } cmd_type;

   // one classified tick as it travels through the queue
   typedef struct packed {
      cmd_type              kind;
      logic [ByteWidth-1:0] write_data;
      logic                 send_ack;
      logic                 sda_in;
   } tick_type;

endpackage

// ===== hw/rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Request side: decodes the command code of each tick into a command kind.
// ----------------------------------------------------------------------------
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic [CmdWidth-1:0]  req_command,
   input  logic [ByteWidth-1:0] req_write_data,
   input  logic                 req_send_ack,
   input  logic                 req_sda_in,
   output tick_type             tick
);

   cmd_type kind;

   // unknown codes behave as no command
   always_comb begin
      unique case (req_command)
         CODE_START:    kind = CMD_START;
         CODE_STOP:     kind = CMD_STOP;
         CODE_WRITE:    kind = CMD_WRITE;
         CODE_WAIT_ACK: kind = CMD_WAIT_ACK;
         CODE_READ:     kind = CMD_READ;
         default:       kind = CMD_NONE;
      endcase
   end

   // only the write command needs its byte
   always_comb begin
      tick.kind       = kind;
      tick.write_data = (kind == CMD_WRITE) ? req_write_data : '0;
      tick.send_ack   = req_send_ack;
      tick.sda_in     = req_sda_in;
   end

endmodule

// ===== hw/rtl/i2cm_queue.sv =====
// ----------------------------------------------------------------------------
// i2cm_queue
// Small fifo of classified ticks between the request side and the sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue
   import i2cm_pkg::*;
#(
   parameter int Depth = DefaultQueueDepth
)(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  tick_type push_tick,
   output logic     full,
   input  logic     pop,
   output logic     head_valid,
   output tick_type head_tick
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   tick_type                slot_ff [Depth];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff, count_in;

   assign full       = (count_ff == FullCount);
   assign head_valid = (count_ff != '0);
   assign head_tick  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tick;
      end
   end

endmodule

// ===== hw/rtl/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Pin sequencer: runs one tick per cycle while the result slot is free or being emptied, and holds the result register.
// ----------------------------------------------------------------------------
module i2cm_back
   import i2cm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [HalfPeriodWidth-1:0] half_period_ticks,
   input  logic [AckTimeoutWidth-1:0] ack_timeout_limit,
   input  logic                       tick_valid,
   input  tick_type                   tick,
   output logic                       tick_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_scl_level,
   output logic                       rsp_sda_drive_enable,
   output logic                       rsp_sda_level,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic [ByteWidth-1:0]       rsp_read_data,
   output logic                       rsp_ack_missing
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B, PH_STOP_C,
      PH_WA_A, PH_WA_B, PH_WA_POLL, PH_WR_HI, PH_WR_LO, PH_RD_LO, PH_RD_HI,
      PH_AK_A, PH_AK_B
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [BitCountWidth-1:0]   bit_count_ff, bit_count_in, bit_count_inc;
   logic [ByteWidth-1:0]       shift_ff, shift_in;
   logic [AckTimeoutWidth-1:0] timeout_ff, timeout_in;
   logic [HalfPeriodWidth-1:0] delay_ff, delay_in, delay_reload;
   logic                       scl_ff, scl_in;
   logic                       sda_ff, sda_in_next;
   logic                       drive_ff, drive_in;
   logic                       ack_choice_ff, ack_choice_in;
   logic [ByteWidth-1:0]       rx_ff, rx_in;
   logic                       miss_ff, miss_in;
   logic                       done;
   logic                       rsp_valid_ff;
   logic                       done_ff;

   // take a tick when the result slot is free or being emptied
   assign tick_pop  = tick_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // a zero half period counts as one tick
   assign delay_reload  = (half_period_ticks == '0) ? HalfPeriodWidth'(1) : half_period_ticks;
   assign bit_count_inc = bit_count_ff + 1'b1;

   // next state of the sequencer for one tick
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      timeout_in    = timeout_ff;
      delay_in      = delay_ff;
      scl_in        = scl_ff;
      sda_in_next   = sda_ff;
      drive_in      = drive_ff;
      ack_choice_in = ack_choice_ff;
      rx_in         = rx_ff;
      miss_in       = miss_ff;
      done          = 1'b0;

      priority if (phase_ff == PH_IDLE) begin
         if (tick.kind != CMD_NONE) begin
            miss_in  = 1'b0;
            delay_in = delay_reload;
         end
         unique case (tick.kind)
            CMD_START: begin
               drive_in = 1'b1; sda_in_next = 1'b1; scl_in = 1'b1;
               phase_in = PH_START_A;
            end
            CMD_STOP: begin
               drive_in = 1'b1; scl_in = 1'b0; sda_in_next = 1'b0;
               phase_in = PH_STOP_A;
            end
            CMD_WRITE: begin
               shift_in     = tick.write_data;
               bit_count_in = '0;
               drive_in     = 1'b1;
               sda_in_next  = tick.write_data[ByteWidth-1];
               scl_in       = 1'b1;
               phase_in     = PH_WR_HI;
            end
            CMD_WAIT_ACK: begin
               drive_in    = 1'b0; sda_in_next = 1'b1;
               timeout_in  = '0;
               phase_in    = PH_WA_A;
            end
            CMD_READ: begin
               ack_choice_in = tick.send_ack;
               bit_count_in  = '0;
               shift_in      = '0;
               drive_in      = 1'b0; sda_in_next = 1'b1; scl_in = 1'b0;
               phase_in      = PH_RD_LO;
            end
            default: begin
            end
         endcase
      end else if (phase_ff == PH_WA_POLL) begin
         // poll for the acknowledge every tick
         priority if (!tick.sda_in) begin
            scl_in   = 1'b0;
            phase_in = PH_IDLE;
            done     = 1'b1;
         end else if (timeout_ff >= ack_timeout_limit) begin
            miss_in     = 1'b1;
            drive_in    = 1'b1; scl_in = 1'b0; sda_in_next = 1'b0;
            delay_in    = delay_reload;
            phase_in    = PH_STOP_A;
         end else begin
            timeout_in = timeout_ff + 1'b1;
         end
      end else if (delay_ff > HalfPeriodWidth'(1)) begin
         delay_in = delay_ff - 1'b1;
      end else begin
         // delay unit over: step to the next pin change
         delay_in = delay_reload;
         unique case (phase_ff)
            PH_START_A: begin sda_in_next = 1'b0; phase_in = PH_START_B; end
            PH_START_B: begin scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1; end
            PH_STOP_A:  begin scl_in = 1'b1; phase_in = PH_STOP_B; end
            PH_STOP_B:  begin sda_in_next = 1'b1; phase_in = PH_STOP_C; end
            PH_STOP_C:  begin phase_in = PH_IDLE; done = 1'b1; end
            PH_WA_A:    begin scl_in = 1'b1; phase_in = PH_WA_B; end
            PH_WA_B:    begin phase_in = PH_WA_POLL; end
            PH_WR_HI:   begin scl_in = 1'b0; phase_in = PH_WR_LO; end
            PH_WR_LO: begin
               shift_in     = {shift_ff[ByteWidth-2:0], 1'b0};
               bit_count_in = bit_count_inc;
               if (bit_count_inc >= BitsPerByte) begin
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end else begin
                  sda_in_next = shift_ff[ByteWidth-2];
                  scl_in      = 1'b1;
                  phase_in    = PH_WR_HI;
               end
            end
            PH_RD_LO: begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[ByteWidth-2:0], tick.sda_in};
               phase_in = PH_RD_HI;
            end
            PH_RD_HI: begin
               bit_count_in = bit_count_inc;
               scl_in       = 1'b0;
               if (bit_count_inc >= BitsPerByte) begin
                  rx_in       = shift_ff;
                  drive_in    = 1'b1;
                  sda_in_next = !ack_choice_ff;
                  phase_in    = PH_AK_A;
               end else begin
                  phase_in = PH_RD_LO;
               end
            end
            PH_AK_A:  begin scl_in = 1'b1; phase_in = PH_AK_B; end
            PH_AK_B:  begin scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1; end
            default:  begin phase_in = PH_IDLE; end
         endcase
      end
   end

   // sequencer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         timeout_ff    <= '0;
         delay_ff      <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         ack_choice_ff <= 1'b0;
         rx_ff         <= '0;
         miss_ff       <= 1'b0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (tick_pop) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_ff      <= shift_in;
            timeout_ff    <= timeout_in;
            delay_ff      <= delay_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in_next;
            drive_ff      <= drive_in;
            ack_choice_ff <= ack_choice_in;
            rx_ff         <= rx_in;
            miss_ff       <= miss_in;
            done_ff       <= done;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // result fields come straight from the state after the tick
   assign rsp_scl_level        = scl_ff;
   assign rsp_sda_drive_enable = drive_ff;
   assign rsp_sda_level        = drive_ff ? sda_ff : 1'b1;
   assign rsp_busy_res         = (phase_ff != PH_IDLE);
   assign rsp_done_res         = done_ff;
   assign rsp_read_data        = rx_ff;
   assign rsp_ack_missing      = miss_ff;

endmodule

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master pin sequencer: one tick per item, each tick gives the pin levels.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              carries
//  req_*     in   req_valid/req_ready    command, write byte, ack choice, sda
//  rsp_*     out  rsp_valid/rsp_ready    scl, sda drive/level, flags, rx byte
//  csr_*     in   csr_write_enable       half period, ack timeout limit
//
//  one tick is taken per clock while the queue is not full; its result passes
//  through a queue slot, then the sequencer's result register
//  the queue holds QueueDepth ticks, so the request side keeps flowing until
//  the queue is full while rsp_ready is low
//  reset is synchronous; state returns to idle with scl and sda driven high
// ----------------------------------------------------------------------------
module i2c_master_bit_engine
   import i2cm_pkg::*;
#(
   parameter int QueueDepth = DefaultQueueDepth
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CmdWidth-1:0]      req_command,
   input  logic [ByteWidth-1:0]     req_write_data,
   input  logic                     req_send_ack,
   input  logic                     req_sda_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_scl_level,
   output logic                     rsp_sda_drive_enable,
   output logic                     rsp_sda_level,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic [ByteWidth-1:0]     rsp_read_data,
   output logic                     rsp_ack_missing,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   logic [HalfPeriodWidth-1:0] half_period_ff;
   logic [AckTimeoutWidth-1:0] ack_timeout_ff;
   tick_type                   front_tick;
   tick_type                   head_tick;
   logic                       queue_full;
   logic                       head_valid;
   logic                       head_pop;
   logic                       push;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HalfPeriodReset;
         ack_timeout_ff <= AckTimeoutReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: half_period_ff <= csr_write_data[HalfPeriodWidth-1:0];
            CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_write_data[AckTimeoutWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // command decode
   i2cm_front u_front (
      .req_command    (req_command),
      .req_write_data (req_write_data),
      .req_send_ack   (req_send_ack),
      .req_sda_in     (req_sda_in),
      .tick           (front_tick)
   );

   // tick queue
   i2cm_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_tick  (front_tick),
      .full       (queue_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_tick  (head_tick)
   );

   // pin sequencer
   i2cm_back u_back (
      .clock                (clock),
      .reset                (reset),
      .half_period_ticks    (half_period_ff),
      .ack_timeout_limit    (ack_timeout_ff),
      .tick_valid           (head_valid),
      .tick                 (head_tick),
      .tick_pop             (head_pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_scl_level        (rsp_scl_level),
      .rsp_sda_drive_enable (rsp_sda_drive_enable),
      .rsp_sda_level        (rsp_sda_level),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_read_data        (rsp_read_data),
      .rsp_ack_missing      (rsp_ack_missing)
   );

endmodule
